// ===== hdl/hbs_pkg.sv =====
package hbs_pkg;

   localparam int ID_W    = 4;
   localparam int TVAL_W  = 20;
   localparam int TIME_W  = 32;
   localparam int MASK_W  = 10;
   localparam int MAX_TASKS = 16;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_REPORT = 3'd1,
      OP_INJECT = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_CHECK  = 3'd4,
      OP_SETTMO = 3'd5,
      OP_ARM    = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      REASON_NONE   = 2'd0,
      REASON_FAULT  = 2'd1,
      REASON_SILENT = 2'd2,
      REASON_LATE   = 2'd3
   } reason_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic exec;
      logic scan_start;
      logic scan_next;
      logic check_done;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic scan_hit;
      logic scan_end;
   } sts_type;

   // timeout of each task after reset
   function automatic logic [TIME_W-1:0] reset_timeout(input int idx);
      logic [TIME_W-1:0] val;
      case (idx)
         1:       val = 32'd6000;
         2:       val = 32'd8000;
         3:       val = 32'd4000;
         4:       val = 32'd7000;
         5:       val = 32'd2000;
         8:       val = 32'd4000;
         default: val = 32'd3000;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/multi_task_heartbeat_supervisor.sv =====
// Heartbeat supervisor for up to NUM_TASKS tasks: every accepted item gives exactly one
// result item. Tick, report, inject, clear, set-timeout and arm items are executed when
// accepted, and their result is in the output register on the next cycle. A check item
// walks the task table one entry per cycle in index order, up to the first failing task
// or the last task, using the single shared elapsed-time compare. The input is held
// off during a check scan and while a previous result is stalled in the output register.
module multi_task_heartbeat_supervisor #(
   parameter int NUM_TASKS    = 10,
   parameter int TIMEOUT_BITS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_cmd,
   input  logic [hbs_pkg::ID_W-1:0]   req_task_id,
   input  logic [hbs_pkg::TVAL_W-1:0] req_timeout_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_healthy,
   output logic                       rsp_feed_watchdog,
   output logic [hbs_pkg::ID_W-1:0]   rsp_fail_task,
   output logic [1:0]                 rsp_fail_reason,
   output logic [hbs_pkg::TIME_W-1:0] rsp_fail_last_report,
   output logic [hbs_pkg::TIME_W-1:0] rsp_now_time,
   output logic [hbs_pkg::TIME_W-1:0] rsp_check_total,
   output logic [hbs_pkg::TIME_W-1:0] rsp_fail_total,
   output logic [hbs_pkg::MASK_W-1:0] rsp_fault_bits,
   output logic [hbs_pkg::MASK_W-1:0] rsp_reported_bits,
   output logic                       rsp_armed
);
   import hbs_pkg::*;

   ctl_type ctl;
   sts_type sts;

   hbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   hbs_datapath #(
      .NUM_TASKS    (NUM_TASKS),
      .TIMEOUT_BITS (TIMEOUT_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_cmd              (req_cmd),
      .req_task_id          (req_task_id),
      .req_timeout_value    (req_timeout_value),
      .ctl                  (ctl),
      .sts                  (sts),
      .rsp_healthy          (rsp_healthy),
      .rsp_feed_watchdog    (rsp_feed_watchdog),
      .rsp_fail_task        (rsp_fail_task),
      .rsp_fail_reason      (rsp_fail_reason),
      .rsp_fail_last_report (rsp_fail_last_report),
      .rsp_now_time         (rsp_now_time),
      .rsp_check_total      (rsp_check_total),
      .rsp_fail_total       (rsp_fail_total),
      .rsp_fault_bits       (rsp_fault_bits),
      .rsp_reported_bits    (rsp_reported_bits),
      .rsp_armed            (rsp_armed)
   );

endmodule

// ===== hdl/hbs_ctrl.sv =====
module hbs_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [2:0]      req_cmd,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  hbs_pkg::sts_type sts,
   output hbs_pkg::ctl_type ctl
);
   import hbs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      is_check;

   assign is_check  = (op_type'(req_cmd) == OP_CHECK);
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_check) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_hit || sts.scan_end) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.exec       = accept && !is_check;
            ctl.scan_start = accept && is_check;
         end
         ST_SCAN: begin
            ctl.check_done = sts.scan_hit || sts.scan_end;
            ctl.scan_next  = !(sts.scan_hit || sts.scan_end);
         end
         default: ctl = '0;
      endcase
   end

   always_comb begin
      if (ctl.exec || ctl.check_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/hbs_datapath.sv =====
module hbs_datapath #(
   parameter int NUM_TASKS    = 10,
   parameter int TIMEOUT_BITS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [2:0]                 req_cmd,
   input  logic [hbs_pkg::ID_W-1:0]   req_task_id,
   input  logic [hbs_pkg::TVAL_W-1:0] req_timeout_value,
   input  hbs_pkg::ctl_type           ctl,
   output hbs_pkg::sts_type           sts,
   output logic                       rsp_healthy,
   output logic                       rsp_feed_watchdog,
   output logic [hbs_pkg::ID_W-1:0]   rsp_fail_task,
   output logic [1:0]                 rsp_fail_reason,
   output logic [hbs_pkg::TIME_W-1:0] rsp_fail_last_report,
   output logic [hbs_pkg::TIME_W-1:0] rsp_now_time,
   output logic [hbs_pkg::TIME_W-1:0] rsp_check_total,
   output logic [hbs_pkg::TIME_W-1:0] rsp_fail_total,
   output logic [hbs_pkg::MASK_W-1:0] rsp_fault_bits,
   output logic [hbs_pkg::MASK_W-1:0] rsp_reported_bits,
   output logic                       rsp_armed
);
   import hbs_pkg::*;

   localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   // supervisor state
   logic [TIME_W-1:0]       tick_ff, tick_in;
   logic [TIME_W-1:0]       last_ff [NUM_TASKS];
   logic [TIME_W-1:0]       last_in [NUM_TASKS];
   logic [TIMEOUT_BITS-1:0] tmo_ff  [NUM_TASKS];
   logic [TIMEOUT_BITS-1:0] tmo_in  [NUM_TASKS];
   logic [NUM_TASKS-1:0]    rep_ff, rep_in;
   logic [NUM_TASKS-1:0]    fault_ff, fault_in;
   logic [TIME_W-1:0]       chk_ff, chk_in;
   logic [TIME_W-1:0]       fail_ff, fail_in;
   logic                    armed_ff, armed_in;
   logic [IW-1:0]           scan_ff, scan_in;

   // result register
   logic                    healthy_ff, healthy_in;
   logic                    feed_ff, feed_in;
   logic [ID_W-1:0]         ftask_ff, ftask_in;
   logic [1:0]              freason_ff, freason_in;
   logic [TIME_W-1:0]       flast_ff, flast_in;
   logic [TIME_W-1:0]       now_ff;
   logic [TIME_W-1:0]       chk_out_ff;
   logic [TIME_W-1:0]       fail_out_ff;
   logic [MASK_W-1:0]       fault_out_ff, rep_out_ff;
   logic                    armed_out_ff;

   logic                    id_ok;
   logic [TIME_W-1:0]       cur_last;
   logic [TIME_W-1:0]       elapsed;
   reason_type              cur_reason;
   logic                    load_rsp;

   assign id_ok = ({1'b0, req_task_id} < (ID_W + 1)'(NUM_TASKS));

   // one task entry per scan cycle
   assign cur_last = last_ff[scan_ff];
   assign elapsed  = tick_ff - cur_last;

   always_comb begin
      if (fault_ff[scan_ff]) begin
         cur_reason = REASON_FAULT;
      end else if (!rep_ff[scan_ff]) begin
         cur_reason = REASON_SILENT;
      end else if (elapsed > TIME_W'(tmo_ff[scan_ff])) begin
         cur_reason = REASON_LATE;
      end else begin
         cur_reason = REASON_NONE;
      end
   end

   assign sts.scan_hit = (cur_reason != REASON_NONE);
   assign sts.scan_end = (scan_ff == IW'(NUM_TASKS - 1));

   always_comb begin
      tick_in  = tick_ff;
      last_in  = last_ff;
      tmo_in   = tmo_ff;
      rep_in   = rep_ff;
      fault_in = fault_ff;
      chk_in   = chk_ff;
      fail_in  = fail_ff;
      armed_in = armed_ff;
      scan_in  = scan_ff;

      if (ctl.scan_start) scan_in = '0;
      if (ctl.scan_next)  scan_in = scan_ff + IW'(1);

      if (ctl.check_done) begin
         chk_in = chk_ff + TIME_W'(1);
         if (sts.scan_hit) fail_in = fail_ff + TIME_W'(1);
      end

      if (ctl.exec) begin
         unique case (op_type'(req_cmd))
            OP_TICK: tick_in = tick_ff + TIME_W'(1);
            OP_REPORT: begin
               for (int i = 0; i < NUM_TASKS; i++) begin
                  if (id_ok && req_task_id == ID_W'(i) && !fault_ff[i]) begin
                     last_in[i] = tick_ff;
                     rep_in[i]  = 1'b1;
                  end
               end
            end
            OP_INJECT: begin
               for (int i = 0; i < NUM_TASKS; i++) begin
                  if (id_ok && req_task_id == ID_W'(i)) begin
                     fault_in[i] = 1'b1;
                     rep_in[i]   = 1'b0;
                     last_in[i]  = '0;
                  end
               end
            end
            OP_CLEAR: fault_in = '0;
            OP_SETTMO: begin
               for (int i = 0; i < NUM_TASKS; i++) begin
                  if (id_ok && req_task_id == ID_W'(i)) begin
                     tmo_in[i] = TIMEOUT_BITS'(req_timeout_value);
                  end
               end
            end
            OP_ARM: begin
               for (int i = 0; i < NUM_TASKS; i++) begin
                  last_in[i] = tick_ff;
               end
               rep_in   = '1;
               armed_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // failure fields only carry data on a failed check
   always_comb begin
      healthy_in = 1'b0;
      feed_in    = 1'b0;
      ftask_in   = '0;
      freason_in = REASON_NONE;
      flast_in   = '0;
      if (ctl.check_done) begin
         if (sts.scan_hit) begin
            ftask_in   = ID_W'(scan_ff);
            freason_in = cur_reason;
            flast_in   = cur_last;
         end else begin
            healthy_in = 1'b1;
            feed_in    = armed_ff;
         end
      end
   end

   assign load_rsp = ctl.exec || ctl.check_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         rep_ff   <= '0;
         fault_ff <= '0;
         chk_ff   <= '0;
         fail_ff  <= '0;
         armed_ff <= 1'b0;
         scan_ff  <= '0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            last_ff[i] <= '0;
            tmo_ff[i]  <= TIMEOUT_BITS'(reset_timeout(i));
         end
      end else begin
         tick_ff  <= tick_in;
         rep_ff   <= rep_in;
         fault_ff <= fault_in;
         chk_ff   <= chk_in;
         fail_ff  <= fail_in;
         armed_ff <= armed_in;
         scan_ff  <= scan_in;
         last_ff  <= last_in;
         tmo_ff   <= tmo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         healthy_ff   <= healthy_in;
         feed_ff      <= feed_in;
         ftask_ff     <= ftask_in;
         freason_ff   <= freason_in;
         flast_ff     <= flast_in;
         now_ff       <= tick_in;
         chk_out_ff   <= chk_in;
         fail_out_ff  <= fail_in;
         fault_out_ff <= MASK_W'(MAX_TASKS'(fault_in));
         rep_out_ff   <= MASK_W'(MAX_TASKS'(rep_in));
         armed_out_ff <= armed_in;
      end
   end

   assign rsp_healthy          = healthy_ff;
   assign rsp_feed_watchdog    = feed_ff;
   assign rsp_fail_task        = ftask_ff;
   assign rsp_fail_reason      = freason_ff;
   assign rsp_fail_last_report = flast_ff;
   assign rsp_now_time         = now_ff;
   assign rsp_check_total      = chk_out_ff;
   assign rsp_fail_total       = fail_out_ff;
   assign rsp_fault_bits       = fault_out_ff;
   assign rsp_reported_bits    = rep_out_ff;
   assign rsp_armed            = armed_out_ff;

endmodule
